// ----- hw/rtl/lhew_pkg.sv -----
package lhew_pkg;

  // result action codes
  typedef enum logic [2:0] {
    ACT_NONE           = 3'd0,
    ACT_MEM_RESTART    = 3'd1,
    ACT_LOCK_RESTART   = 3'd2,
    ACT_RADIO_RESET    = 3'd3,
    ACT_DETACH_RESTART = 3'd4
  } action_t;

  // indicator colors
  typedef enum logic [1:0] {
    IND_NONE  = 2'd0,
    IND_RED   = 2'd1,
    IND_GREEN = 2'd2
  } indicator_t;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRACE        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MEM_CRITICAL = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MEM_WARNING  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_RADIO_AFTER  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOST_AFTER   = 3'd4;

  localparam int unsigned CFG_DATA_W = 32;

  // configuration reset values
  localparam logic [15:0] GRACE_RESET        = 16'd60;
  localparam logic [15:0] MEM_CRITICAL_RESET = 16'd10;
  localparam logic [15:0] MEM_WARNING_RESET  = 16'd20;
  localparam logic [31:0] RADIO_AFTER_RESET  = 32'd1800;
  localparam logic [31:0] HOST_AFTER_RESET   = 32'd3600;

  // lowest role code that counts as attached
  localparam logic [2:0] ROLE_CHILD = 3'd2;

  typedef struct packed {
    logic [31:0] uptime_seconds;
    logic [15:0] free_memory_kb;
    logic        lock_obtained;
    logic        instance_present;
    logic [2:0]  link_role;
  } tick_t;

  typedef struct packed {
    action_t    action;
    logic       memory_warning;
    indicator_t indicator;
    logic       first_attach;
  } result_t;

  typedef struct packed {
    logic [15:0] grace_seconds;
    logic [15:0] memory_critical_kb;
    logic [15:0] memory_warning_kb;
    logic [31:0] radio_reset_after_s;
    logic [31:0] host_restart_after_s;
  } cfg_t;

  typedef struct packed {
    logic        ever_attached;
    logic        detach_watch_valid;
    logic [31:0] detach_start_time;
    logic        radio_reset_done;
  } wd_state_t;

  localparam wd_state_t STATE_RESET = '{
    ever_attached:      1'b0,
    detach_watch_valid: 1'b0,
    detach_start_time:  32'd0,
    radio_reset_done:   1'b0
  };

endpackage

// ----- hw/rtl/link_health_escalation_watchdog_core.sv -----
// path: an accepted tick beat is held in the tick register and evaluated as it moves into the result register
// throughput: one tick per cycle, sustained, with result_ready held high
// the rate is set by the single evaluation stage between the tick and result registers
// stalls: a full tick register is still refilled in the cycle its beat moves on
// reset (rst, synchronous, active high) empties both stages, clears the watchdog
//   state and loads the configuration registers with their default values
module link_health_escalation_watchdog_core (
  input  logic                                clk,
  input  logic                                rst,
  // tick channel
  input  logic                                tick_valid,
  output logic                                tick_ready,
  input  lhew_pkg::tick_t                     tick,
  // result channel
  output logic                                result_valid,
  input  logic                                result_ready,
  output lhew_pkg::result_t                   result,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lhew_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lhew_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // input stage
  logic                 hold_valid;
  lhew_pkg::tick_t      hold_tick;

  // watchdog state and evaluation outputs
  lhew_pkg::wd_state_t  state;
  lhew_pkg::wd_state_t  state_next;
  lhew_pkg::result_t    eval_res;
  lhew_pkg::cfg_t       cfg;

  // handshake control
  logic                 out_free;
  logic                 advance;
  logic                 tick_fire;

  // configuration registers, always ready; writes must come only while idle, the block itself does not enforce it
  assign cfg_ready = 1'b1;

  lhew_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // result register can take a beat when empty or being drained this cycle
  assign out_free   = !result_valid || result_ready;
  // the held tick is evaluated and committed when it moves into the result register
  assign advance    = hold_valid && out_free;
  // tick register refills when empty or when its beat moves on
  assign tick_ready = !hold_valid || out_free;
  assign tick_fire  = tick_valid && tick_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (tick_ready) begin
      hold_valid <= tick_valid;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (tick_fire) begin
      hold_tick <= tick;
    end
  end

  // single pass decision: grace, memory, lock, instance, then link role
  lhew_eval u_eval (
    .tick    (hold_tick),
    .cfg     (cfg),
    .st      (state),
    .res     (eval_res),
    .st_next (state_next)
  );

  // watchdog state only changes as a tick commits
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lhew_pkg::STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= eval_res;
    end
  end

  // a radio reset needs a running detach watch
  a_done_needs_watch: assert property (@(posedge clk) disable iff (rst)
    state.radio_reset_done |-> state.detach_watch_valid)
    else $error("radio reset marked without detach watch");

  // the detach watch only runs after a first attach
  a_watch_needs_attach: assert property (@(posedge clk) disable iff (rst)
    state.detach_watch_valid |-> state.ever_attached)
    else $error("detach watch running before any attach");

  // every restart action returns the state to reset
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    advance && (eval_res.action == lhew_pkg::ACT_MEM_RESTART ||
                eval_res.action == lhew_pkg::ACT_LOCK_RESTART ||
                eval_res.action == lhew_pkg::ACT_DETACH_RESTART)
    |=> state == lhew_pkg::STATE_RESET)
    else $error("restart did not clear watchdog state");

  // state holds when no tick commits
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("watchdog state changed without a tick");

  // radio reset and first attach always report green
  a_green_report: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.action == lhew_pkg::ACT_RADIO_RESET || result.first_attach)
    |-> result.indicator == lhew_pkg::IND_GREEN)
    else $error("radio reset or first attach not reported green");

endmodule

// ----- hw/rtl/lhew_cfg.sv -----
module lhew_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [lhew_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lhew_pkg::CFG_DATA_W-1:0]     cfg_data,
  output lhew_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grace_seconds        <= lhew_pkg::GRACE_RESET;
      cfg.memory_critical_kb   <= lhew_pkg::MEM_CRITICAL_RESET;
      cfg.memory_warning_kb    <= lhew_pkg::MEM_WARNING_RESET;
      cfg.radio_reset_after_s  <= lhew_pkg::RADIO_AFTER_RESET;
      cfg.host_restart_after_s <= lhew_pkg::HOST_AFTER_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lhew_pkg::CFG_GRACE:        cfg.grace_seconds        <= cfg_data[15:0];
        lhew_pkg::CFG_MEM_CRITICAL: cfg.memory_critical_kb   <= cfg_data[15:0];
        lhew_pkg::CFG_MEM_WARNING:  cfg.memory_warning_kb    <= cfg_data[15:0];
        lhew_pkg::CFG_RADIO_AFTER:  cfg.radio_reset_after_s  <= cfg_data[31:0];
        lhew_pkg::CFG_HOST_AFTER:   cfg.host_restart_after_s <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/lhew_eval.sv -----
module lhew_eval (
  input  lhew_pkg::tick_t      tick,
  input  lhew_pkg::cfg_t       cfg,
  input  lhew_pkg::wd_state_t  st,
  output lhew_pkg::result_t    res,
  output lhew_pkg::wd_state_t  st_next
);

  logic [31:0] start_eff;
  logic [31:0] elapsed;
  logic        in_grace;
  logic        mem_critical;
  logic        mem_warning;
  logic        attached;

  // a fresh detach watch starts at this tick, so elapsed is zero
  assign start_eff    = st.detach_watch_valid ? st.detach_start_time : tick.uptime_seconds;
  assign elapsed      = tick.uptime_seconds - start_eff;
  assign in_grace     = tick.uptime_seconds < {16'd0, cfg.grace_seconds};
  assign mem_critical = tick.free_memory_kb < cfg.memory_critical_kb;
  assign mem_warning  = tick.free_memory_kb < cfg.memory_warning_kb;
  assign attached     = tick.link_role >= lhew_pkg::ROLE_CHILD;

  always_comb begin
    res.action         = lhew_pkg::ACT_NONE;
    res.memory_warning = 1'b0;
    res.indicator      = lhew_pkg::IND_NONE;
    res.first_attach   = 1'b0;
    st_next            = st;
    priority if (in_grace) begin
      // ignored tick
    end else if (mem_critical) begin
      res.action    = lhew_pkg::ACT_MEM_RESTART;
      res.indicator = lhew_pkg::IND_RED;
      st_next       = lhew_pkg::STATE_RESET;
    end else begin
      res.memory_warning = mem_warning;
      priority if (!tick.lock_obtained) begin
        res.action    = lhew_pkg::ACT_LOCK_RESTART;
        res.indicator = lhew_pkg::IND_RED;
        st_next       = lhew_pkg::STATE_RESET;
      end else if (!tick.instance_present) begin
        // no instance, nothing to supervise
      end else if (attached) begin
        res.first_attach           = !st.ever_attached;
        res.indicator              = lhew_pkg::IND_GREEN;
        st_next.ever_attached      = 1'b1;
        st_next.detach_watch_valid = 1'b0;
        st_next.detach_start_time  = 32'd0;
        st_next.radio_reset_done   = 1'b0;
      end else if (st.ever_attached) begin
        st_next.detach_watch_valid = 1'b1;
        st_next.detach_start_time  = start_eff;
        priority if (elapsed >= cfg.host_restart_after_s && st.radio_reset_done) begin
          res.action    = lhew_pkg::ACT_DETACH_RESTART;
          res.indicator = lhew_pkg::IND_RED;
          st_next       = lhew_pkg::STATE_RESET;
        end else if (elapsed >= cfg.radio_reset_after_s && !st.radio_reset_done) begin
          res.action                = lhew_pkg::ACT_RADIO_RESET;
          res.indicator             = lhew_pkg::IND_GREEN;
          st_next.radio_reset_done  = 1'b1;
          st_next.detach_start_time = tick.uptime_seconds;
        end else begin
          // still waiting on the detach timer
        end
      end else begin
        // detached before any attach, timer stays idle
      end
    end
  end

endmodule

// ----- tb/link_health_escalation_watchdog_core_tb.sv -----
`timescale 1ns / 100ps

module link_health_escalation_watchdog_core_tb;

  // role codes, only child is named by the package
  localparam logic [2:0] ROLE_DISABLED = 3'd0;
  localparam logic [2:0] ROLE_DETACHED = 3'd1;
  localparam logic [2:0] ROLE_ROUTER = 3'd3;
  localparam logic [2:0] ROLE_LEADER = 3'd4;
  localparam logic [2:0] ROLE_SPARE_LO = 3'd5;
  localparam logic [2:0] ROLE_SPARE_MID = 3'd6;
  localparam logic [2:0] ROLE_SPARE_HI = 3'd7;

  localparam int STALL_LIMIT = 600;
  localparam int HOLD_CYCLES = 60;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_TICKS = 105;

  // mirrors the watchdog state and holds the actions still owed by the block
  class watchdog_mirror;
    lhew_pkg::cfg_t     regs;
    logic               attached;
    logic               watching;
    logic [31:0]        watch_start;
    logic               radio_done;
    lhew_pkg::result_t  awaited[$];
    int                 mismatches;

    function new();
      regs.grace_seconds = lhew_pkg::GRACE_RESET;
      regs.memory_critical_kb = lhew_pkg::MEM_CRITICAL_RESET;
      regs.memory_warning_kb = lhew_pkg::MEM_WARNING_RESET;
      regs.radio_reset_after_s = lhew_pkg::RADIO_AFTER_RESET;
      regs.host_restart_after_s = lhew_pkg::HOST_AFTER_RESET;
      clear_watch();
      mismatches = 0;
    endfunction

    function void clear_watch();
      attached = 1'b0;
      watching = 1'b0;
      watch_start = '0;
      radio_done = 1'b0;
    endfunction

    function void write_reg(logic [lhew_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] data);
      case (idx)
        lhew_pkg::CFG_GRACE:        regs.grace_seconds = data[15:0];
        lhew_pkg::CFG_MEM_CRITICAL: regs.memory_critical_kb = data[15:0];
        lhew_pkg::CFG_MEM_WARNING:  regs.memory_warning_kb = data[15:0];
        lhew_pkg::CFG_RADIO_AFTER:  regs.radio_reset_after_s = data;
        lhew_pkg::CFG_HOST_AFTER:   regs.host_restart_after_s = data;
        default: ;
      endcase
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // work out the action for one accepted tick beat
    function void take_tick(lhew_pkg::tick_t t);
      lhew_pkg::result_t r;
      logic [31:0]       elapsed;
      r.action = lhew_pkg::ACT_NONE;
      r.memory_warning = 1'b0;
      r.indicator = lhew_pkg::IND_NONE;
      r.first_attach = 1'b0;
      if (t.uptime_seconds < {16'd0, regs.grace_seconds}) begin
        // startup grace, nothing moves
      end else if (t.free_memory_kb < regs.memory_critical_kb) begin
        r.action = lhew_pkg::ACT_MEM_RESTART;
        r.indicator = lhew_pkg::IND_RED;
        clear_watch();
      end else begin
        r.memory_warning = t.free_memory_kb < regs.memory_warning_kb;
        if (!t.lock_obtained) begin
          r.action = lhew_pkg::ACT_LOCK_RESTART;
          r.indicator = lhew_pkg::IND_RED;
          clear_watch();
        end else if (!t.instance_present) begin
          // no stack instance, nothing to supervise
        end else if (t.link_role >= lhew_pkg::ROLE_CHILD) begin
          if (!attached) begin
            r.first_attach = 1'b1;
            attached = 1'b1;
          end
          watching = 1'b0;
          watch_start = '0;
          radio_done = 1'b0;
          r.indicator = lhew_pkg::IND_GREEN;
        end else if (attached) begin
          if (!watching) begin
            watching = 1'b1;
            watch_start = t.uptime_seconds;
          end
          elapsed = t.uptime_seconds - watch_start;
          if (elapsed >= regs.host_restart_after_s && radio_done) begin
            r.action = lhew_pkg::ACT_DETACH_RESTART;
            r.indicator = lhew_pkg::IND_RED;
            clear_watch();
          end else if (elapsed >= regs.radio_reset_after_s && !radio_done) begin
            // red then green within the tick, green is what shows
            r.action = lhew_pkg::ACT_RADIO_RESET;
            r.indicator = lhew_pkg::IND_GREEN;
            radio_done = 1'b1;
            watch_start = t.uptime_seconds;
          end
        end
      end
      awaited.push_back(r);
    endfunction

    function void match_result(lhew_pkg::result_t got);
      lhew_pkg::result_t exp;
      if (awaited.size() == 0) begin
        report($sformatf("result beat with nothing awaited: action %0d warn %0d ind %0d first %0d",
                         got.action, got.memory_warning, got.indicator, got.first_attach));
        return;
      end
      exp = awaited.pop_front();
      if (got.action !== exp.action || got.memory_warning !== exp.memory_warning ||
          got.indicator !== exp.indicator || got.first_attach !== exp.first_attach)
        report($sformatf("action %0d/%0d warn %0d/%0d ind %0d/%0d first %0d/%0d (exp/got)",
                         exp.action, got.action, exp.memory_warning, got.memory_warning,
                         exp.indicator, got.indicator, exp.first_attach, got.first_attach));
    endfunction
  endclass

  logic                              clk;
  logic                              rst = 1'b1;
  logic                              tick_valid = 1'b0;
  logic                              tick_ready;
  lhew_pkg::tick_t                   tick = '0;
  logic                              result_valid;
  logic                              result_ready = 1'b0;
  lhew_pkg::result_t                 result;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [lhew_pkg::CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [lhew_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

  watchdog_mirror mirror;

  // stimulus context
  lhew_pkg::cfg_t phase_cfg;
  logic [31:0]    sim_uptime;
  logic           link_up_run;
  logic           tick_steady;
  logic           result_steady;
  logic           hold_req;

  link_health_escalation_watchdog_core dut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_ready   (tick_ready),
    .tick         (tick),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic lhew_pkg::tick_t make_tick(logic [31:0] up, logic [15:0] mem,
                                                logic lock_ok, logic inst, logic [2:0] role);
    lhew_pkg::tick_t t;
    t.uptime_seconds = up;
    t.free_memory_kb = mem;
    t.lock_obtained = lock_ok;
    t.instance_present = inst;
    t.link_role = role;
    return t;
  endfunction

  // write all five registers, block must be idle
  task automatic configure(input lhew_pkg::cfg_t c);
    logic [lhew_pkg::CFG_INDEX_W-1:0] idx;
    logic [31:0]                      val;
    for (int i = 0; i < 5; i++) begin
      idx = i[lhew_pkg::CFG_INDEX_W-1:0];
      // narrow registers get junk in the upper half, it must be dropped
      case (idx)
        lhew_pkg::CFG_GRACE:        val = {16'($urandom), c.grace_seconds};
        lhew_pkg::CFG_MEM_CRITICAL: val = {16'($urandom), c.memory_critical_kb};
        lhew_pkg::CFG_MEM_WARNING:  val = {16'($urandom), c.memory_warning_kb};
        lhew_pkg::CFG_RADIO_AFTER:  val = c.radio_reset_after_s;
        default:                    val = c.host_restart_after_s;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= val;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      mirror.write_reg(idx, val);
    end
    cfg_valid <= 1'b0;
    phase_cfg = c;
  endtask

  // offer one tick beat, with a random gap in front unless in a steady stretch
  task automatic send_tick(input lhew_pkg::tick_t t);
    int gap;
    if ($urandom_range(0, 19) == 0) tick_steady = !tick_steady;
    gap = tick_steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      tick_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick <= t;
    @(posedge clk);
    while (!tick_ready) @(posedge clk);
    mirror.take_tick(t);
  endtask

  // stop offering and wait for every awaited result beat
  task automatic drain_results();
    tick_valid <= 1'b0;
    @(posedge clk);
    while (mirror.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic lhew_pkg::cfg_t pick_config();
    lhew_pkg::cfg_t c;
    case ($urandom_range(0, 9))
      0:       c.grace_seconds = 16'd0;
      1:       c.grace_seconds = 16'hFFFF;
      default: c.grace_seconds = 16'($urandom_range(0, 300));
    endcase
    case ($urandom_range(0, 9))
      0:       c.memory_critical_kb = 16'd0;
      1:       c.memory_critical_kb = 16'hFFFF;
      default: c.memory_critical_kb = 16'($urandom_range(0, 64));
    endcase
    case ($urandom_range(0, 9))
      0:       c.memory_warning_kb = 16'd0;
      1:       c.memory_warning_kb = 16'hFFFF;
      default: c.memory_warning_kb = 16'($urandom_range(0, 128));
    endcase
    case ($urandom_range(0, 9))
      0:       c.radio_reset_after_s = 32'd0;
      1:       c.radio_reset_after_s = 32'hFFFF_FFFF;
      2:       c.radio_reset_after_s = lhew_pkg::RADIO_AFTER_RESET;
      default: c.radio_reset_after_s = $urandom_range(0, 400);
    endcase
    case ($urandom_range(0, 9))
      0:       c.host_restart_after_s = 32'd0;
      1:       c.host_restart_after_s = 32'hFFFF_FFFF;
      2:       c.host_restart_after_s = lhew_pkg::HOST_AFTER_RESET;
      default: c.host_restart_after_s = $urandom_range(0, 400);
    endcase
    return c;
  endfunction

  // mostly healthy ticks with runs of attached and detached roles
  function automatic lhew_pkg::tick_t random_tick();
    int          pick;
    int unsigned warn_top;
    logic [15:0] mem;
    logic [2:0]  role;
    pick = $urandom_range(0, 99);
    if (pick < 3) sim_uptime = $urandom;
    else if (pick < 5) sim_uptime = sim_uptime - $urandom_range(0, 100);
    else sim_uptime = sim_uptime + $urandom_range(0, 80);
    warn_top = int'(phase_cfg.memory_warning_kb) + 8;
    if (warn_top > 65535) warn_top = 65535;
    pick = $urandom_range(0, 99);
    if (pick < 4) mem = 16'($urandom_range(0, phase_cfg.memory_critical_kb));
    else if (pick < 15) mem = 16'($urandom_range(0, warn_top));
    else mem = 16'($urandom);
    if ($urandom_range(0, 99) < 10) link_up_run = !link_up_run;
    role = link_up_run ? 3'($urandom_range(2, 7)) : 3'($urandom_range(0, 1));
    return make_tick(sim_uptime, mem, $urandom_range(0, 99) >= 3,
                     $urandom_range(0, 99) >= 4, role);
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) result_steady = !result_steady;
      stall = result_steady ? 0 : $urandom_range(0, 9);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = stall + HOLD_CYCLES;
      end
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      mirror.match_result(result);
    end
  end

  // timeout when no beat moves on any channel for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (tick_valid && tick_ready) || (result_valid && result_ready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    lhew_pkg::cfg_t c;
    mirror = new();
    tick_steady = 1'b0;
    result_steady = 1'b0;
    hold_req = 1'b0;
    link_up_run = 1'b0;
    sim_uptime = '0;
    phase_cfg = mirror.regs;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: grace 60, critical 10, warning 20, radio 1800, host 3600
    send_tick(make_tick(32'd59, 16'd0, 1'b0, 1'b0, ROLE_DISABLED));     // in grace
    send_tick(make_tick(32'd60, 16'd9, 1'b1, 1'b1, lhew_pkg::ROLE_CHILD)); // memory restart
    // lock restart, warning
    send_tick(make_tick(32'd60, 16'd10, 1'b0, 1'b1, lhew_pkg::ROLE_CHILD));
    send_tick(make_tick(32'd61, 16'd20, 1'b1, 1'b0, lhew_pkg::ROLE_CHILD)); // no instance
    send_tick(make_tick(32'd62, 16'hFFFF, 1'b1, 1'b1, ROLE_DETACHED));  // detach before attach
    send_tick(make_tick(32'd63, 16'd100, 1'b1, 1'b1, lhew_pkg::ROLE_CHILD)); // first attach
    send_tick(make_tick(32'd1000, 16'd100, 1'b1, 1'b1, ROLE_DETACHED)); // timer starts
    send_tick(make_tick(32'd2800, 16'd100, 1'b1, 1'b1, ROLE_DISABLED)); // radio reset
    send_tick(make_tick(32'd6399, 16'd100, 1'b1, 1'b1, ROLE_DETACHED)); // one second short
    send_tick(make_tick(32'd6400, 16'd100, 1'b1, 1'b1, ROLE_DETACHED)); // host restart
    send_tick(make_tick(32'd6500, 16'd100, 1'b1, 1'b1, ROLE_SPARE_HI)); // unused role attaches
    send_tick(make_tick(32'hFFFF_FF00, 16'd100, 1'b1, 1'b1, ROLE_DETACHED));
    send_tick(make_tick(32'h0000_0700, 16'd100, 1'b1, 1'b1, ROLE_DETACHED)); // wrapped elapsed
    send_tick(make_tick(32'hFFFF_FFFF, 16'd19, 1'b1, 1'b1, ROLE_LEADER));
    send_tick(make_tick(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, ROLE_SPARE_LO));
    drain_results();

    // all thresholds but warning at zero: both escalations fire on back to back detached ticks
    c.grace_seconds = 16'd0;
    c.memory_critical_kb = 16'd0;
    c.memory_warning_kb = 16'hFFFF;
    c.radio_reset_after_s = 32'd0;
    c.host_restart_after_s = 32'd0;
    configure(c);
    send_tick(make_tick(32'd0, 16'd0, 1'b1, 1'b1, lhew_pkg::ROLE_CHILD));
    send_tick(make_tick(32'd5, 16'd0, 1'b1, 1'b1, ROLE_DETACHED));
    send_tick(make_tick(32'd6, 16'd0, 1'b1, 1'b1, ROLE_DETACHED));
    send_tick(make_tick(32'd7, 16'hFFFF, 1'b1, 1'b1, ROLE_DISABLED));
    drain_results();

    // everything at the top of its range, but the warning threshold at zero
    c.grace_seconds = 16'hFFFF;
    c.memory_critical_kb = 16'hFFFF;
    c.memory_warning_kb = 16'd0;
    c.radio_reset_after_s = 32'hFFFF_FFFF;
    c.host_restart_after_s = 32'hFFFF_FFFF;
    configure(c);
    send_tick(make_tick(32'd65534, 16'd0, 1'b1, 1'b1, ROLE_ROUTER));
    send_tick(make_tick(32'd65535, 16'hFFFE, 1'b1, 1'b1, ROLE_ROUTER));
    send_tick(make_tick(32'd65535, 16'hFFFF, 1'b0, 1'b1, ROLE_ROUTER));
    send_tick(make_tick(32'd65535, 16'hFFFF, 1'b1, 1'b1, ROLE_SPARE_MID));
    send_tick(make_tick(32'h0001_0000, 16'hFFFF, 1'b1, 1'b1, ROLE_DETACHED));
    send_tick(make_tick(32'h0000_FFFF, 16'hFFFF, 1'b1, 1'b1, ROLE_DISABLED)); // elapsed all ones
    drain_results();

    // random phases, a fresh setting each, drained before the next write
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      configure(pick_config());
      sim_uptime = $urandom_range(0, 400);
      link_up_run = 1'b1;
      // one phase runs with the result side held off so the block backs up
      if (p == 1) hold_req = 1'b1;
      for (int n = 0; n < PHASE_TICKS; n++) send_tick(random_tick());
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
